// ===== sv/xtm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtm_pkg
// shared constants and types for the xor trie multiset engine
// ----------------------------------------------------------------------------
package xtm_pkg;
  localparam int ValueBits = 8;
  localparam int CountBits = 16;
  localparam int NodeBits  = ValueBits + 1;
  localparam int NodeTotal = 2 << ValueBits;

  typedef logic [3:0] func_t;
  localparam func_t FnAdd     = 4'd0;
  localparam func_t FnDelete  = 4'd1;
  localparam func_t FnClear   = 4'd2;
  localparam func_t FnPrefix  = 4'd3;
  localparam func_t FnKthMin  = 4'd4;
  localparam func_t FnKthMax  = 4'd5;
  localparam func_t FnLt      = 4'd6;
  localparam func_t FnLeq     = 4'd7;
  localparam func_t FnGt      = 4'd8;
  localparam func_t FnGeq     = 4'd9;
  localparam func_t FnLower   = 4'd10;
  localparam func_t FnFloor   = 4'd11;
  localparam func_t FnHigher  = 4'd12;
  localparam func_t FnCeil    = 4'd13;
  localparam func_t FnSize    = 4'd14;

  typedef logic [1:0] status_t;
  localparam status_t StOk       = 2'd0;
  localparam status_t StRank     = 2'd1;
  localparam status_t StOverflow = 2'd2;

  // memory access request from the controller to the count store
  typedef struct packed {
    logic                rd;
    logic [NodeBits-1:0] raddr;
    logic                wr;
    logic [NodeBits-1:0] waddr;
    logic [CountBits-1:0] wdata;
  } mem_req_t;
endpackage

// ===== sv/xor_trie_multiset_engine.sv =====
`timescale 1ns / 1ps
// add and delete do a read-modify-write over the nine path nodes of the key
// one item at a time; busy stays high while an item is in work
// reset clears all 512 count store entries with a sweep, busy high meanwhile
// out_valid is one cycle wide; the receiver cannot stall
// ----------------------------------------------------------------------------
// xor_trie_multiset_engine
// multiset of keys held as node counts of a dense binary trie
// ----------------------------------------------------------------------------
module xor_trie_multiset_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_func,
  input  logic [7:0]  in_key,
  input  logic [7:0]  in_xor_mask,
  input  logic [15:0] in_amount,
  input  logic [15:0] in_rank,
  input  logic [3:0]  in_prefix_skip,
  input  logic [7:0]  in_fallback,
  output logic        out_valid,
  output logic [7:0]  out_result_value,
  output logic [15:0] out_result_count,
  output logic        out_found,
  output logic [1:0]  out_status
);
  xtm_pkg::mem_req_t             req;
  logic [xtm_pkg::CountBits-1:0] rdata;
  logic                          mem_ready;

  xtm_count_ram u_ram (
    .clk(clk), .rst_n(rst_n), .req(req), .rdata(rdata), .ready(mem_ready)
  );

  xtm_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .mem_ready(mem_ready), .start(start), .busy(busy),
    .in_func(in_func), .in_key(in_key), .in_xor_mask(in_xor_mask),
    .in_amount(in_amount), .in_rank(in_rank), .in_prefix_skip(in_prefix_skip),
    .in_fallback(in_fallback), .req(req), .rdata(rdata), .out_valid(out_valid),
    .out_result_value(out_result_value), .out_result_count(out_result_count),
    .out_found(out_found), .out_status(out_status)
  );
endmodule

// ===== sv/xtm_count_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtm_count_ram
// node count store, one write and one registered read port, clearing sweep
// ----------------------------------------------------------------------------
module xtm_count_ram (
  input  logic                           clk,
  input  logic                           rst_n,
  input  xtm_pkg::mem_req_t              req,
  output logic [xtm_pkg::CountBits-1:0]  rdata,
  output logic                           ready
);
  logic [xtm_pkg::CountBits-1:0] mem [xtm_pkg::NodeTotal];
  logic [xtm_pkg::NodeBits:0]    clr_r;
  logic [xtm_pkg::NodeBits:0]    clr_nxt;

  assign ready   = clr_r[xtm_pkg::NodeBits];
  assign clr_nxt = clr_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (!ready) begin
      clr_r <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!ready) begin
      mem[clr_r[xtm_pkg::NodeBits-1:0]] <= '0;
    end else if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.raddr];
    end
  end
endmodule

// ===== sv/xtm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtm_ctrl
// sequencer that walks the trie levels through the count store
// ----------------------------------------------------------------------------
module xtm_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           mem_ready,
  input  logic                           start,
  output logic                           busy,
  input  xtm_pkg::func_t                 in_func,
  input  logic [xtm_pkg::ValueBits-1:0]  in_key,
  input  logic [xtm_pkg::ValueBits-1:0]  in_xor_mask,
  input  logic [15:0]                    in_amount,
  input  logic [15:0]                    in_rank,
  input  logic [3:0]                     in_prefix_skip,
  input  logic [xtm_pkg::ValueBits-1:0]  in_fallback,
  output xtm_pkg::mem_req_t              req,
  input  logic [xtm_pkg::CountBits-1:0]  rdata,
  output logic                           out_valid,
  output logic [xtm_pkg::ValueBits-1:0]  out_result_value,
  output logic [15:0]                    out_result_count,
  output logic                           out_found,
  output xtm_pkg::status_t               out_status
);
  localparam int VB = xtm_pkg::ValueBits;
  localparam int CB = xtm_pkg::CountBits;
  localparam int NB = xtm_pkg::NodeBits;
  localparam int LB = $clog2(VB + 2);

  typedef enum logic [3:0] {
    S_IDLE, S_RDSIZE, S_RDLEAF, S_DECIDE, S_WALK, S_PREFIX,
    S_CNTLAST, S_CNTDONE, S_SELSTART, S_SEL, S_SELDONE, S_DONE
  } state_t;

  state_t                state_r;
  xtm_pkg::func_t        func_r;
  logic [VB-1:0]         key_r, xm_r, fb_r, elem_r;
  logic [15:0]           amount_r, rank_r;
  logic [3:0]            skip_r;
  logic [CB-1:0]         size_r, leaf_r, acc_r, rest_r, delta_r;
  logic [LB-1:0]         lvl_r;
  logic [NB-1:0]         cur_r;
  logic                  wup_r;
  logic                  walk_rd_r;
  logic                  sel_max_r;
  logic [NB-1:0]         pend_addr_r;
  logic [VB-1:0]         val_r;
  logic [15:0]           cnt_r;
  logic                  found_r;
  xtm_pkg::status_t      st_r;
  logic                  ov_r;

  logic [LB-1:0]         bit_i;
  logic                  bx, bv, bs;
  logic [VB-1:0]         xv;
  logic [CB:0]           sum_add;
  logic [3:0]            skip_c;
  logic [NB-1:0]         pfx_addr;
  logic [NB-1:0]         path_addr;

  assign busy = (state_r != S_IDLE) || !mem_ready;
  assign out_valid = ov_r;
  assign out_result_value = val_r;
  assign out_result_count = cnt_r;
  assign out_found = found_r;
  assign out_status = st_r;

  assign bit_i  = LB'(VB - 1) - lvl_r;
  assign xv     = xm_r ^ key_r;
  assign bx     = xm_r[bit_i[$clog2(VB)-1:0]];
  assign bv     = xv[bit_i[$clog2(VB)-1:0]];
  assign bs     = xm_r[bit_i[$clog2(VB)-1:0]] ^ sel_max_r;
  assign sum_add = {1'b0, size_r} + {{(CB - 16 + 1){1'b0}}, amount_r};
  assign skip_c = (skip_r > 4'(VB)) ? 4'(VB) : skip_r;
  assign pfx_addr = NB'((({{NB{1'b0}}, 1'b1} << (VB - skip_c)) |
                    (NB'(key_r) >> skip_c)));
  // node on the key path at depth lvl
  assign path_addr = NB'(({{NB{1'b0}}, 1'b1} << lvl_r) | (NB'(key_r) >> (LB'(VB) - lvl_r)));

  always_comb begin
    req = '0;
    unique case (state_r)
      S_IDLE: begin
        req.rd = 1'b1;
        req.raddr = NB'(1);
      end
      S_RDSIZE: begin
        req.rd = 1'b1;
        req.raddr = NB'({1'b1, key_r});
      end
      S_WALK: begin
        req.rd = 1'b1;
        req.raddr = path_addr;
        req.wr = walk_rd_r;
        req.waddr = pend_addr_r;
        req.wdata = wup_r ? rdata + delta_r : rdata - delta_r;
      end
      S_PREFIX: begin
        req.rd = 1'b1;
        req.raddr = pfx_addr;
      end
      S_CNTLAST, S_CNTDONE, S_SELDONE, S_DONE, S_DECIDE, S_RDLEAF,
      S_SELSTART: ;
      S_SEL: begin
        req.rd = 1'b1;
        req.raddr = {cur_r[NB-2:0], bs};
      end
      default: ;
    endcase
    if (state_r == S_DECIDE && func_r >= xtm_pkg::FnLt && func_r <= xtm_pkg::FnCeil) begin
      req.rd = 1'b1;
      req.raddr = {cur_r[NB-2:0], bx};
    end
    if (state_r == S_CNTLAST) begin
      req.rd = 1'b1;
      req.raddr = {cur_r[NB-2:0], bx};
    end
    if (state_r == S_CNTDONE) begin
      req.rd = 1'b1;
      req.raddr = NB'({1'b1, xv});
    end
  end

  logic [CB-1:0] cb_c, cm_c, tgt;
  logic          have_tgt;
  logic [CB-1:0] sel_sz;
  logic [VB-1:0] bitmask;

  assign bitmask = VB'(1) << bit_i;
  // in S_SELSTART rdata holds the leaf count of xm ^ key, acc_r the below count
  assign cb_c    = acc_r;
  assign cm_c    = acc_r + rdata;
  assign sel_sz  = rdata;

  // rank to select for neighbour queries
  always_comb begin
    have_tgt = 1'b0;
    tgt = '0;
    unique case (func_r)
      xtm_pkg::FnLower, xtm_pkg::FnFloor: begin
        tgt = (func_r == xtm_pkg::FnLower) ? cb_c : cm_c;
        if (tgt != 0) begin
          have_tgt = 1'b1;
          tgt = tgt - 1'b1;
        end
      end
      xtm_pkg::FnHigher, xtm_pkg::FnCeil: begin
        tgt = (func_r == xtm_pkg::FnHigher) ? cm_c : cb_c;
        have_tgt = (tgt < size_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (start && mem_ready) begin
          func_r <= in_func; key_r <= in_key; xm_r <= in_xor_mask;
          amount_r <= in_amount; rank_r <= in_rank; skip_r <= in_prefix_skip;
          fb_r <= in_fallback;
          val_r <= '0; cnt_r <= '0; found_r <= 1'b0; st_r <= xtm_pkg::StOk;
          state_r <= S_RDSIZE;
        end
        S_RDSIZE: begin
          size_r <= rdata;
          state_r <= S_RDLEAF;
        end
        S_RDLEAF: begin
          leaf_r <= rdata;
          cur_r <= NB'(1); lvl_r <= '0; acc_r <= '0; walk_rd_r <= 1'b0;
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          state_r <= S_DONE;
          priority case (1'b1)
            func_r == xtm_pkg::FnAdd: if (amount_r != 0) begin
              if (sum_add[CB] || sum_add[CB-1:0] > {CB{1'b1}}) begin
                st_r <= xtm_pkg::StOverflow; cnt_r <= 16'(leaf_r);
              end else begin
                delta_r <= CB'(amount_r); wup_r <= 1'b1;
                cnt_r <= 16'(leaf_r + CB'(amount_r));
                state_r <= S_WALK;
              end
            end
            func_r == xtm_pkg::FnDelete || func_r == xtm_pkg::FnClear: begin
              if (func_r == xtm_pkg::FnClear || CB'(amount_r) >= leaf_r ||
                  amount_r > 16'(leaf_r)) begin
                delta_r <= leaf_r; cnt_r <= 16'(leaf_r);
              end else begin
                delta_r <= CB'(amount_r); cnt_r <= amount_r;
              end
              wup_r <= 1'b0;
              if (func_r == xtm_pkg::FnClear || amount_r != 0) state_r <= S_WALK;
            end
            func_r == xtm_pkg::FnPrefix: state_r <= S_PREFIX;
            func_r == xtm_pkg::FnKthMin || func_r == xtm_pkg::FnKthMax: begin
              if (CB'(rank_r) >= size_r || 16'(size_r) <= rank_r) st_r <= xtm_pkg::StRank;
              else begin
                rest_r <= CB'(rank_r); sel_max_r <= (func_r == xtm_pkg::FnKthMax);
                elem_r <= '0;
                state_r <= S_SEL;
              end
            end
            func_r >= xtm_pkg::FnLt && func_r <= xtm_pkg::FnCeil: begin
              cur_r <= {cur_r[NB-2:0], bv};
              walk_rd_r <= (bx != bv);
              lvl_r <= lvl_r + 1'b1;
              state_r <= (VB == 1) ? S_CNTDONE : S_CNTLAST;
            end
            func_r == xtm_pkg::FnSize: cnt_r <= 16'(size_r);
            default: ;
          endcase
        end
        // read-modify-write along the key path, one node per cycle
        S_WALK: begin
          walk_rd_r <= 1'b1;
          pend_addr_r <= path_addr;
          lvl_r <= lvl_r + 1'b1;
          if (walk_rd_r && lvl_r == LB'(VB + 1)) state_r <= S_DONE;
        end
        S_PREFIX: state_r <= S_CNTLAST;
        S_CNTLAST: begin
          if (func_r == xtm_pkg::FnPrefix) begin
            cnt_r <= 16'(rdata);
            state_r <= S_DONE;
          end else begin
            if (walk_rd_r) acc_r <= acc_r + rdata;
            walk_rd_r <= (bx != bv);
            cur_r <= {cur_r[NB-2:0], bv};
            lvl_r <= lvl_r + 1'b1;
            if (lvl_r == LB'(VB - 1)) state_r <= S_CNTDONE;
          end
        end
        S_CNTDONE: begin
          if (walk_rd_r) acc_r <= acc_r + rdata;
          walk_rd_r <= 1'b0;
          state_r <= S_SELSTART;
        end
        S_SELSTART: begin
          state_r <= S_DONE;
          unique case (func_r)
            xtm_pkg::FnLt:  cnt_r <= 16'(cb_c);
            xtm_pkg::FnLeq: cnt_r <= 16'(cm_c);
            xtm_pkg::FnGt:  cnt_r <= 16'(size_r - cm_c);
            xtm_pkg::FnGeq: cnt_r <= 16'(size_r - cb_c);
            default: if (!have_tgt) val_r <= fb_r;
          endcase
          if (have_tgt) begin
            found_r <= 1'b1; rest_r <= tgt; sel_max_r <= 1'b0;
            cur_r <= NB'(1); lvl_r <= '0; elem_r <= '0;
            state_r <= S_SEL;
          end
        end
        S_SEL: state_r <= S_SELDONE;
        S_SELDONE: begin
          if (sel_sz <= rest_r) begin
            rest_r <= rest_r - sel_sz;
            cur_r <= {cur_r[NB-2:0], ~bs};
            if (~bs) elem_r <= elem_r | bitmask;
          end else begin
            cur_r <= {cur_r[NB-2:0], bs};
            if (bs) elem_r <= elem_r | bitmask;
          end
          lvl_r <= lvl_r + 1'b1;
          if (lvl_r == LB'(VB - 1)) begin
            val_r <= (sel_sz <= rest_r) ? ((elem_r | (~bs ? bitmask : '0)) ^ xm_r)
                                         : ((elem_r | (bs ? bitmask : '0)) ^ xm_r);
            state_r <= S_DONE;
          end else state_r <= S_SEL;
        end
        S_DONE: begin
          ov_r <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
